// ===== rtl/bpb_pkg.sv =====
// Package for the Blinn-Phong reflectance and density evaluator.
// Holds payload structs, fixed-point constants and register codes.
// No dependencies.
package bpb_pkg;

    // Field widths fixed by the item format.
    localparam int COMPONENT_WIDTH = 16;
    localparam int RESULT_WIDTH    = 32;

    // Fixed-point constants (Q30 values, Q32 reciprocal of pi).
    localparam logic [30:0]        Q30_ONE     = 31'd1073741824;
    localparam logic [30:0]        INVPI_Q32   = 31'd1367130551;
    localparam logic signed [33:0] HORIZON_Q30 = 34'sd107374;
    localparam logic [33:0]        EPS_Q30     = 34'd1074;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register codes, in address order.
    typedef enum logic [2:0] {
        REG_KD_R,
        REG_KD_G,
        REG_KD_B,
        REG_KS_R,
        REG_KS_G,
        REG_KS_B,
        REG_SHIN
    } t_reg;

    // One input item.
    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] out_dir_x;
        logic signed [COMPONENT_WIDTH-1:0] out_dir_y;
        logic signed [COMPONENT_WIDTH-1:0] out_dir_z;
        logic signed [COMPONENT_WIDTH-1:0] surf_normal_x;
        logic signed [COMPONENT_WIDTH-1:0] surf_normal_y;
        logic signed [COMPONENT_WIDTH-1:0] surf_normal_z;
        logic signed [COMPONENT_WIDTH-1:0] in_dir_x;
        logic signed [COMPONENT_WIDTH-1:0] in_dir_y;
        logic signed [COMPONENT_WIDTH-1:0] in_dir_z;
    } t_in;

    // One result item.
    typedef struct packed {
        logic [RESULT_WIDTH-1:0] reflect_red;
        logic [RESULT_WIDTH-1:0] reflect_green;
        logic [RESULT_WIDTH-1:0] reflect_blue;
        logic [RESULT_WIDTH-1:0] sample_density;
        logic                    below_horizon;
    } t_out;

    // Classified item as it waits in the queue.
    typedef struct packed {
        logic [33:0]        num;
        logic signed [33:0] dni;
        logic [33:0]        l2;
        logic               below;
    } t_job;

    // Data that travels beside the arithmetic pipelines.
    typedef struct packed {
        logic [33:0]        aux;
        logic signed [33:0] dni;
        logic               below;
    } t_side;

    // Coefficients derived from the configuration registers.
    typedef struct packed {
        logic [32:0]       coef;
        logic [2:0][14:0]  diff;
        logic [2:0][32:0]  ck;
    } t_coef;

    // Clamp a value to the largest result.
    function automatic logic [RESULT_WIDTH-1:0] saturate(input logic [63:0] v);
        logic [63:0] top;
        top = (64'd1 << RESULT_WIDTH) - 64'd1;
        return (v > top) ? top[RESULT_WIDTH-1:0] : v[RESULT_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/bpb_front.sv =====
// Front end: accepts items, forms the dot products and the horizon test.
// Depends on bpb_pkg.
module bpb_front (
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  bpb_pkg::t_in   i_item,
    input  logic           i_full,
    output logic           o_stall,
    output logic           o_push,
    output bpb_pkg::t_job  o_job
);

    logic signed [31:0] w_no_x, w_no_y, w_no_z, w_ni_x, w_ni_y, w_ni_z;
    logic signed [33:0] w_dno, w_dni;
    logic signed [16:0] w_hx, w_hy, w_hz;
    logic signed [33:0] w_sx, w_sy, w_sz;
    logic signed [34:0] w_l2, w_num;

    // Handshake: hold off while the queue is full or reset is active.
    assign o_stall = i_full || !i_rst_n;
    assign o_push  = i_valid && !o_stall;

    // Dot products of the normal with both directions, exact in Q30.
    assign w_no_x = i_item.surf_normal_x * i_item.out_dir_x;
    assign w_no_y = i_item.surf_normal_y * i_item.out_dir_y;
    assign w_no_z = i_item.surf_normal_z * i_item.out_dir_z;
    assign w_ni_x = i_item.surf_normal_x * i_item.in_dir_x;
    assign w_ni_y = i_item.surf_normal_y * i_item.in_dir_y;
    assign w_ni_z = i_item.surf_normal_z * i_item.in_dir_z;
    assign w_dno  = 34'(w_no_x) + 34'(w_no_y) + 34'(w_no_z);
    assign w_dni  = 34'(w_ni_x) + 34'(w_ni_y) + 34'(w_ni_z);

    // Squared length of the unnormalised half vector.
    assign w_hx = 17'(i_item.out_dir_x) + 17'(i_item.in_dir_x);
    assign w_hy = 17'(i_item.out_dir_y) + 17'(i_item.in_dir_y);
    assign w_hz = 17'(i_item.out_dir_z) + 17'(i_item.in_dir_z);
    assign w_sx = w_hx * w_hx;
    assign w_sy = w_hy * w_hy;
    assign w_sz = w_hz * w_hz;
    assign w_l2 = 35'(w_sx) + 35'(w_sy) + 35'(w_sz);

    // Numerator of the cosine with the half vector.
    assign w_num = 35'(w_dno) + 35'(w_dni);

    // Queue entry.
    always_comb begin
        o_job.num   = w_num[33:0];
        o_job.dni   = w_dni;
        o_job.l2    = w_l2[33:0];
        o_job.below = (w_dni <= bpb_pkg::HORIZON_Q30) || (w_dno <= bpb_pkg::HORIZON_Q30);
    end

endmodule

// ===== rtl/bpb_queue.sv =====
// Short queue that decouples the front end from the arithmetic back end.
// Depends on bpb_pkg.
module bpb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bpb_pkg::t_job  i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_nonempty,
    output bpb_pkg::t_job  o_job
);

    localparam int PtrW = $clog2(bpb_pkg::QUEUE_DEPTH);

    bpb_pkg::t_job   r_mem [bpb_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] r_wptr, r_rptr;
    logic [PtrW:0]   r_count;

    assign o_full     = (r_count == (PtrW+1)'(bpb_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_job      = r_mem[r_rptr];

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The fill count tracks pushes and pops exactly.
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not follow a push");

    a_no_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

endmodule

// ===== rtl/bpb_sqrt.sv =====
// Pipelined integer square root of a 64-bit value, one result bit a stage.
// Carries a sideband beside the root. Depends on bpb_pkg.
module bpb_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [63:0]     i_x,
    input  bpb_pkg::t_side  i_side,
    output logic            o_valid,
    output logic [31:0]     o_root,
    output bpb_pkg::t_side  o_side
);

    localparam int Steps = 32;

    logic [63:0]    r_x [Steps+1];
    logic [63:0]    r_r [Steps+1];
    logic           r_v [Steps+1];
    bpb_pkg::t_side r_s [Steps+1];

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= i_x;
            r_r[0] <= '0;
            r_s[0] <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    // One trial subtraction per stage, from the top bit pair down.
    for (genvar k = 0; k < Steps; k++) begin : g_step
        localparam logic [63:0] Bit = 64'd1 << (62 - 2*k);
        logic [63:0] w_t;
        assign w_t = r_r[k] + Bit;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_x[k] >= w_t) begin
                    r_x[k+1] <= r_x[k] - w_t;
                    r_r[k+1] <= (r_r[k] >> 1) + Bit;
                end else begin
                    r_x[k+1] <= r_x[k];
                    r_r[k+1] <= r_r[k] >> 1;
                end
                r_s[k+1] <= r_s[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    assign o_valid = r_v[Steps];
    assign o_root  = r_r[Steps][31:0];
    assign o_side  = r_s[Steps];

endmodule

// ===== rtl/bpb_back.sv =====
// Back end: half-vector length, cosine division, 16th root, power and
// final scaling, ending in the output register. Depends on bpb_pkg, bpb_sqrt.
module bpb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  bpb_pkg::t_job   i_job,
    output logic            o_pop,
    input  bpb_pkg::t_coef  i_coef,
    input  logic [15:0]     i_shin,
    output logic            o_valid,
    input  logic            i_stall,
    output bpb_pkg::t_out   o_item
);

    localparam int DivSteps = 30;
    localparam int PowSteps = 16;

    logic r_out_v;
    logic w_en;

    // The whole pipe moves while the output register is free or being taken.
    assign w_en    = !r_out_v || !i_stall;
    assign o_pop   = w_en && i_valid;
    assign o_valid = r_out_v;

    // Length of the half vector: isqrt(l2 * 2^30).
    bpb_pkg::t_side w_side_in, w_len_side;
    logic           w_len_v;
    logic [31:0]    w_len;

    always_comb begin
        w_side_in.aux   = i_job.num;
        w_side_in.dni   = i_job.dni;
        w_side_in.below = i_job.below;
    end

    bpb_sqrt u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_x     ({i_job.l2, 30'd0}),
        .i_side  (w_side_in),
        .o_valid (w_len_v),
        .o_root  (w_len),
        .o_side  (w_len_side)
    );

    // Cosine c = num * 2^30 / len, clamped to one: restoring division.
    logic           r_dv   [DivSteps+1];
    logic           r_done [DivSteps+1];
    logic [31:0]    r_rem  [DivSteps+1];
    logic [29:0]    r_q    [DivSteps+1];
    logic [31:0]    r_len  [DivSteps+1];
    bpb_pkg::t_side r_ds   [DivSteps+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_done[0] <= (w_len_side.aux >= {2'b00, w_len});
            r_rem[0]  <= w_len_side.aux[31:0];
            r_q[0]    <= '0;
            r_len[0]  <= w_len;
            r_ds[0]   <= w_len_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (w_en) begin
            r_dv[0] <= w_len_v;
        end
    end

    for (genvar k = 0; k < DivSteps; k++) begin : g_div
        logic [32:0] w_r2;
        logic        w_ge;
        logic [32:0] w_diff;
        assign w_r2   = {r_rem[k], 1'b0};
        assign w_ge   = (w_r2 >= {1'b0, r_len[k]});
        assign w_diff = w_r2 - {1'b0, r_len[k]};

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[k+1]  <= w_ge ? w_diff[31:0] : w_r2[31:0];
                r_q[k+1]    <= {r_q[k][28:0], w_ge};
                r_done[k+1] <= r_done[k];
                r_len[k+1]  <= r_len[k];
                r_ds[k+1]   <= r_ds[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end
    end

    // Cosine, and the cosine carried beside the root chain.
    logic [30:0]    w_c;
    bpb_pkg::t_side w_c_side;

    assign w_c = r_done[DivSteps] ? bpb_pkg::Q30_ONE : {1'b0, r_q[DivSteps]};

    always_comb begin
        w_c_side     = r_ds[DivSteps];
        w_c_side.aux = 34'(w_c);
    end

    // Sixteenth root by four square roots in Q30.
    logic           w_rv [5];
    logic [31:0]    w_rr [5];
    bpb_pkg::t_side w_rs [5];

    assign w_rv[0] = r_dv[DivSteps];
    assign w_rr[0] = 32'(w_c);
    assign w_rs[0] = w_c_side;

    for (genvar k = 0; k < 4; k++) begin : g_root
        bpb_sqrt u_root (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_rv[k]),
            .i_x     ({3'd0, w_rr[k][30:0], 30'd0}),
            .i_side  (w_rs[k]),
            .o_valid (w_rv[k+1]),
            .o_root  (w_rr[k+1]),
            .o_side  (w_rs[k+1])
        );
    end

    // Power of the root by square and multiply, one exponent bit a stage.
    logic           r_pv    [PowSteps+1];
    logic [30:0]    r_pres  [PowSteps+1];
    logic [30:0]    r_pbase [PowSteps+1];
    bpb_pkg::t_side r_ps    [PowSteps+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pres[0]  <= bpb_pkg::Q30_ONE;
            r_pbase[0] <= w_rr[4][30:0];
            r_ps[0]    <= w_rs[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv[0] <= 1'b0;
        end else if (w_en) begin
            r_pv[0] <= w_rv[4];
        end
    end

    for (genvar k = 0; k < PowSteps; k++) begin : g_pow
        logic [61:0] w_mres, w_msq;
        assign w_mres = 62'(r_pres[k]) * 62'(r_pbase[k]);
        assign w_msq  = 62'(r_pbase[k]) * 62'(r_pbase[k]);

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pres[k+1]  <= i_shin[k] ? w_mres[60:30] : r_pres[k];
                r_pbase[k+1] <= w_msq[60:30];
                r_ps[k+1]    <= r_ps[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pv[k+1] <= 1'b0;
            end else if (w_en) begin
                r_pv[k+1] <= r_pv[k];
            end
        end
    end

    // First scaling stage: specular terms, p*c and the diffuse density.
    logic [30:0]      w_p, w_cf;
    logic [61:0]      w_pc;
    logic [2:0][63:0] w_spec;
    logic [33:0]      w_dsum;
    logic [64:0]      w_dprod;

    assign w_p     = r_pres[PowSteps];
    assign w_cf    = r_ps[PowSteps].aux[30:0];
    assign w_pc    = 62'(w_p) * 62'(w_cf);
    assign w_dsum  = {1'b0, r_ps[PowSteps].dni[32:0]} + bpb_pkg::EPS_Q30;
    assign w_dprod = 65'(w_dsum) * 65'(bpb_pkg::INVPI_Q32);

    for (genvar ch = 0; ch < 3; ch++) begin : g_spec
        assign w_spec[ch] = 64'(i_coef.ck[ch]) * 64'(w_p);
    end

    logic             r_f1_v, r_f1_below;
    logic [30:0]      r_f1_pc;
    logic [2:0][25:0] r_f1_spec;
    logic [18:0]      r_f1_densd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1_pc    <= w_pc[60:30];
            r_f1_densd <= w_dprod[64:46];
            r_f1_below <= r_ps[PowSteps].below;
            for (int ch = 0; ch < 3; ch++) begin
                r_f1_spec[ch] <= w_spec[ch][63:38];
            end
        end
    end

    // Second scaling stage: specular density and per-channel sums.
    logic [63:0]      w_dens_s;
    logic             r_f2_v, r_f2_below;
    logic [2:0][31:0] r_f2_refl;
    logic [18:0]      r_f2_densd;
    logic [25:0]      r_f2_denss;

    assign w_dens_s = 64'(i_coef.coef) * 64'(r_f1_pc);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f2_densd <= r_f1_densd;
            r_f2_denss <= w_dens_s[63:38];
            r_f2_below <= r_f1_below;
            for (int ch = 0; ch < 3; ch++) begin
                r_f2_refl[ch] <= bpb_pkg::saturate(
                    64'(i_coef.diff[ch]) + 64'(r_f1_spec[ch]));
            end
        end
    end

    // Output register: density average and the below-horizon override.
    logic [26:0] w_dsum2;
    assign w_dsum2 = 27'(r_f2_densd) + 27'(r_f2_denss);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_f2_below) begin
                o_item.reflect_red    <= '0;
                o_item.reflect_green  <= '0;
                o_item.reflect_blue   <= '0;
                o_item.sample_density <= '1;
                o_item.below_horizon  <= 1'b1;
            end else begin
                o_item.reflect_red    <= r_f2_refl[0];
                o_item.reflect_green  <= r_f2_refl[1];
                o_item.reflect_blue   <= r_f2_refl[2];
                o_item.sample_density <= bpb_pkg::saturate(64'(w_dsum2[26:1]));
                o_item.below_horizon  <= 1'b0;
            end
        end
    end

    // Valid bits of the scaling stages and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v  <= 1'b0;
            r_f2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_f1_v  <= r_pv[PowSteps];
            r_f2_v  <= r_f1_v;
            r_out_v <= r_f2_v;
        end
    end

endmodule

// ===== rtl/blinn_phong_brdf_and_pdf_eval.sv =====
// Throughput: one item per cycle while the output is not stalled; the back end is a
// fully pipelined chain of five square-root pipelines, a 30-stage divider and a
// 16-stage power unit.
// A four-entry queue lets the front keep accepting while the back end is stalled.
// Reset is synchronous, active low: clears all valid bits and loads register defaults.
// Depends on bpb_pkg, bpb_front, bpb_queue, bpb_back.
module blinn_phong_brdf_and_pdf_eval (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  bpb_pkg::t_in   i_item,
    output logic           o_valid,
    input  logic           i_stall,
    output bpb_pkg::t_out  o_item,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    logic [2:0][15:0] r_kd, r_ks;
    logic [15:0]      r_shin;
    bpb_pkg::t_coef   r_coef;
    logic             w_wr;
    bpb_pkg::t_reg    w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_reg  = bpb_pkg::t_reg'(paddr[4:2]);

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kd   <= {3{16'd32768}};
            r_ks   <= '0;
            r_shin <= 16'd512;
        end else if (w_wr) begin
            case (w_reg)
                bpb_pkg::REG_KD_R: r_kd[0] <= pwdata[15:0];
                bpb_pkg::REG_KD_G: r_kd[1] <= pwdata[15:0];
                bpb_pkg::REG_KD_B: r_kd[2] <= pwdata[15:0];
                bpb_pkg::REG_KS_R: r_ks[0] <= pwdata[15:0];
                bpb_pkg::REG_KS_G: r_ks[1] <= pwdata[15:0];
                bpb_pkg::REG_KS_B: r_ks[2] <= pwdata[15:0];
                bpb_pkg::REG_SHIN: r_shin  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_reg)
            bpb_pkg::REG_KD_R: prdata = 32'(r_kd[0]);
            bpb_pkg::REG_KD_G: prdata = 32'(r_kd[1]);
            bpb_pkg::REG_KD_B: prdata = 32'(r_kd[2]);
            bpb_pkg::REG_KS_R: prdata = 32'(r_ks[0]);
            bpb_pkg::REG_KS_G: prdata = 32'(r_ks[1]);
            bpb_pkg::REG_KS_B: prdata = 32'(r_ks[2]);
            bpb_pkg::REG_SHIN: prdata = 32'(r_shin);
            default:           prdata = '0;
        endcase
    end

    // Coefficients that depend only on the registers, settled while idle.
    logic [47:0]      w_coef_prod;
    logic [2:0][46:0] w_diff_prod;
    logic [2:0][48:0] w_ck_prod;

    assign w_coef_prod = 48'(17'(r_shin) + 17'd32) * 48'(bpb_pkg::INVPI_Q32);

    for (genvar ch = 0; ch < 3; ch++) begin : g_coef
        assign w_diff_prod[ch] = 47'(r_kd[ch]) * 47'(bpb_pkg::INVPI_Q32);
        assign w_ck_prod[ch]   = 49'(r_coef.coef) * 49'(r_ks[ch]);
    end

    always_ff @(posedge i_clk) begin
        r_coef.coef <= w_coef_prod[47:15];
        for (int ch = 0; ch < 3; ch++) begin
            r_coef.diff[ch] <= w_diff_prod[ch][46:32];
            r_coef.ck[ch]   <= w_ck_prod[ch][48:16];
        end
    end

    // Front end, queue and back end.
    logic          w_full, w_push, w_pop, w_nonempty;
    bpb_pkg::t_job w_job_in, w_job_out;

    bpb_front u_front (
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_stall (o_stall),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    bpb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_job_in),
        .i_pop      (w_pop),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_job      (w_job_out)
    );

    bpb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_nonempty),
        .i_job   (w_job_out),
        .o_pop   (w_pop),
        .i_coef  (r_coef),
        .i_shin  (r_shin),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    // A flagged item carries zero reflectance and a saturated density.
    a_below_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.below_horizon |->
            o_item.reflect_red == '0 && o_item.reflect_green == '0 &&
            o_item.reflect_blue == '0 && o_item.sample_density == '1)
        else $error("below-horizon item has wrong result");

    // A shininess write lands in the register on the next cycle.
    a_shin_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr && w_reg == bpb_pkg::REG_SHIN |=> r_shin == $past(pwdata[15:0]))
        else $error("shininess write lost");

endmodule

// ===== tb/bpb_checker.sv =====
// Checker for the Blinn-Phong reflectance and density evaluator.
// Watches both channels and the register port, predicts each result and compares it.
// Depends on bpb_pkg.
module bpb_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           o_stall,
    input  bpb_pkg::t_in   i_item,
    input  logic           o_valid,
    input  logic           i_stall,
    input  bpb_pkg::t_out  o_item,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    input  logic           pready,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] UNIT_Q30 = 64'd1 << 30;
    localparam logic [63:0] RECIP_PI = 64'd1367130551;

    logic [15:0]   kd_reg [3];
    logic [15:0]   ks_reg [3];
    logic [15:0]   shine_reg;
    bpb_pkg::t_out shade_queue [$];

    assign o_pending = shade_queue.size();

    // Floor square root of a 64-bit value.
    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Raise a Q30 cosine to a Q12.4 exponent.
    function automatic logic [63:0] cos_power(input logic [63:0] c, input logic [15:0] e);
        logic [63:0] base, acc;
        base = c;
        acc = UNIT_Q30;
        for (int k = 0; k < 4; k++) base = root_floor(base << 30);
        while (e != 0) begin
            if (e[0]) acc = (acc * base) >> 30;
            base = (base * base) >> 30;
            e >>= 1;
        end
        return acc;
    endfunction

    function automatic logic [31:0] clamp32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Expected shading result for one item.
    function automatic bpb_pkg::t_out shade(input bpb_pkg::t_in it);
        logic signed [31:0] wo [3], nv [3], wi [3], hv [3];
        logic signed [63:0] dno, dni, l2s;
        logic [63:0] len, num, c, p, coef, dd, ds, diff, ck, spec;
        bpb_pkg::t_out r;
        wo[0] = it.out_dir_x;  wo[1] = it.out_dir_y;  wo[2] = it.out_dir_z;
        nv[0] = it.surf_normal_x; nv[1] = it.surf_normal_y; nv[2] = it.surf_normal_z;
        wi[0] = it.in_dir_x;   wi[1] = it.in_dir_y;   wi[2] = it.in_dir_z;
        dno = 0;
        dni = 0;
        l2s = 0;
        for (int i = 0; i < 3; i++) begin
            hv[i] = wo[i] + wi[i];
            dno += 64'(nv[i]) * 64'(wo[i]);
            dni += 64'(nv[i]) * 64'(wi[i]);
            l2s += 64'(hv[i]) * 64'(hv[i]);
        end
        r = '0;
        if (dni <= 64'sd107374 || dno <= 64'sd107374) begin
            r.sample_density = '1;
            r.below_horizon = 1'b1;
            return r;
        end
        len = root_floor(64'(l2s) << 30);
        num = 64'(dno) + 64'(dni);
        c = (len == 0) ? UNIT_Q30 : (num << 30) / len;
        if (c > UNIT_Q30) c = UNIT_Q30;
        p = cos_power(c, shine_reg);
        coef = ((64'(shine_reg) + 64'd32) * RECIP_PI) >> 15;
        for (int i = 0; i < 3; i++) begin
            diff = (64'(kd_reg[i]) * RECIP_PI) >> 32;
            ck = (coef * 64'(ks_reg[i])) >> 16;
            spec = (ck * p) >> 38;
            if (i == 0) r.reflect_red = clamp32(diff + spec);
            else if (i == 1) r.reflect_green = clamp32(diff + spec);
            else r.reflect_blue = clamp32(diff + spec);
        end
        dd = ((64'(dni) + 64'd1074) * RECIP_PI) >> 46;
        ds = (coef * ((p * c) >> 30)) >> 38;
        r.sample_density = clamp32((dd + ds) >> 1);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    // Track registers, predict on each accepted item, compare each accepted result.
    always @(posedge i_clk) begin
        bpb_pkg::t_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                kd_reg[i] <= 16'd32768;
                ks_reg[i] <= 16'd0;
            end
            shine_reg <= 16'd512;
            o_fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (bpb_pkg::t_reg'(paddr[4:2]))
                    bpb_pkg::REG_KD_R: kd_reg[0] <= pwdata[15:0];
                    bpb_pkg::REG_KD_G: kd_reg[1] <= pwdata[15:0];
                    bpb_pkg::REG_KD_B: kd_reg[2] <= pwdata[15:0];
                    bpb_pkg::REG_KS_R: ks_reg[0] <= pwdata[15:0];
                    bpb_pkg::REG_KS_G: ks_reg[1] <= pwdata[15:0];
                    bpb_pkg::REG_KS_B: ks_reg[2] <= pwdata[15:0];
                    bpb_pkg::REG_SHIN: shine_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) shade_queue.push_back(shade(i_item));
            if (o_valid && !i_stall) begin
                if (shade_queue.size() == 0) begin
                    report_mismatch("unexpected result", o_item.reflect_red, 32'd0);
                end else begin
                    want = shade_queue.pop_front();
                    if (o_item.reflect_red !== want.reflect_red)
                        report_mismatch("reflect_red", o_item.reflect_red, want.reflect_red);
                    if (o_item.reflect_green !== want.reflect_green)
                        report_mismatch("reflect_green", o_item.reflect_green,
                                        want.reflect_green);
                    if (o_item.reflect_blue !== want.reflect_blue)
                        report_mismatch("reflect_blue", o_item.reflect_blue, want.reflect_blue);
                    if (o_item.sample_density !== want.sample_density)
                        report_mismatch("sample_density", o_item.sample_density,
                                        want.sample_density);
                    if (o_item.below_horizon !== want.below_horizon)
                        report_mismatch("below_horizon", 32'(o_item.below_horizon),
                                        32'(want.below_horizon));
                end
            end
        end
    end
endmodule

// ===== tb/testbench.sv =====
// Top of the testbench for the Blinn-Phong reflectance and density evaluator.
// Drives items, registers and output stalls; the checker judges the results.
// Depends on bpb_pkg, blinn_phong_brdf_and_pdf_eval and bpb_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    bpb_pkg::t_in  i_item = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    bpb_pkg::t_out o_item;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;
    int            fail_count;
    int            pending;
    bit            calm_tail = 1'b0;

    blinn_phong_brdf_and_pdf_eval DUT (.*);

    bpb_checker checker_inst (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item, .o_valid, .i_stall, .o_item,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50ms;
        $display("blinn_phong_brdf_and_pdf_eval verification failed");
        $finish;
    end

    // Output stall in random bursts, none near the end.
    initial begin
        forever begin
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            if (!calm_tail && $urandom_range(0, 1)) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input bpb_pkg::t_reg idx, input logic [15:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Wait for every expected result, then let the pipeline drain.
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (240) @(posedge i_clk);
    endtask

    // Present one item and hold it until accepted.
    task automatic send_item(input bpb_pkg::t_in it, input bit gaps);
        if (gaps && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_comp();
        return 16'($urandom);
    endfunction

    // Well-formed directions: normal near +z, both directions in the upper hemisphere.
    function automatic bpb_pkg::t_in upper_item();
        bpb_pkg::t_in it;
        it = '0;
        it.surf_normal_x = 16'($signed($urandom_range(0, 8000)) - 4000);
        it.surf_normal_y = 16'($signed($urandom_range(0, 8000)) - 4000);
        it.surf_normal_z = 16'($urandom_range(28000, 32767));
        it.out_dir_x = 16'($signed($urandom_range(0, 40000)) - 20000);
        it.out_dir_y = 16'($signed($urandom_range(0, 40000)) - 20000);
        it.out_dir_z = 16'($urandom_range(2000, 32767));
        it.in_dir_x = 16'($signed($urandom_range(0, 40000)) - 20000);
        it.in_dir_y = 16'($signed($urandom_range(0, 40000)) - 20000);
        it.in_dir_z = 16'($urandom_range(2000, 32767));
        return it;
    endfunction

    function automatic bpb_pkg::t_in noise_item();
        bpb_pkg::t_in it;
        it = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
              rand_comp(), rand_comp(), rand_comp(), rand_comp()};
        return it;
    endfunction

    task automatic set_material(input logic [15:0] kd, input logic [15:0] ks,
                                input logic [15:0] ns);
        write_reg(bpb_pkg::REG_KD_R, kd);
        write_reg(bpb_pkg::REG_KD_G, ~kd);
        write_reg(bpb_pkg::REG_KD_B, kd ^ 16'h5A5A);
        write_reg(bpb_pkg::REG_KS_R, ks);
        write_reg(bpb_pkg::REG_KS_G, ~ks);
        write_reg(bpb_pkg::REG_KS_B, ks ^ 16'hA5A5);
        write_reg(bpb_pkg::REG_SHIN, ns);
    endtask

    task automatic random_phase(input int count, input bit gaps);
        bpb_pkg::t_in it;
        for (int i = 0; i < count; i++) begin
            it = ($urandom_range(0, 4) == 0) ? noise_item() : upper_item();
            send_item(it, gaps);
        end
        i_valid <= 1'b0;
    endtask

    initial begin
        bpb_pkg::t_in it;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at reset settings: horizon cases, extremes, near-zero half vectors.
        it = '0;
        it.surf_normal_z = 16'h7FFF; it.out_dir_z = 16'h7FFF; it.in_dir_z = 16'h7FFF;
        send_item(it, 0);
        it.in_dir_z = 16'd0;
        send_item(it, 0);
        it.in_dir_z = 16'd3; it.out_dir_z = 16'd3;
        send_item(it, 0);
        it.in_dir_z = 16'd4; it.out_dir_z = 16'd4;
        send_item(it, 0);
        it.in_dir_z = 16'h7FFF; it.out_dir_z = 16'h8000;
        send_item(it, 0);
        it = '0;
        it.surf_normal_x = 16'h8000; it.out_dir_x = 16'h8000; it.in_dir_x = 16'h8000;
        it.surf_normal_y = 16'h8000; it.out_dir_y = 16'h8000; it.in_dir_y = 16'h8000;
        send_item(it, 0);
        it = '1;
        send_item(it, 0);
        it = '0;
        it.surf_normal_z = 16'h7FFF; it.out_dir_x = 16'h7FFF; it.out_dir_z = 16'd100;
        it.in_dir_x = 16'h8001; it.in_dir_z = 16'd100;
        send_item(it, 0);
        for (int i = 0; i < 6; i++) send_item(upper_item(), 0);
        i_valid <= 1'b0;
        drain();

        // Settings sweep: extremes and zero shininess, then random materials.
        set_material(16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 6; i++) send_item(upper_item(), 0);
        i_valid <= 1'b0;
        drain();
        set_material(16'h0000, 16'hFFFF, 16'h0000);
        random_phase(100, 1);
        drain();
        set_material(16'h0000, 16'h0000, 16'd16);
        random_phase(150, 1);
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            set_material(16'($urandom), 16'($urandom), 16'($urandom_range(0, 2048)));
            random_phase(130, 1);
            drain();
        end
        set_material(16'h8000, 16'h4000, 16'd512);
        calm_tail = 1'b1;
        random_phase(60, 0);

        while (pending != 0) @(posedge i_clk);
        repeat (240) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("blinn_phong_brdf_and_pdf_eval verification clean");
        end else begin
            $display("blinn_phong_brdf_and_pdf_eval verification failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/bpb_pkg.sv
rtl/bpb_front.sv
rtl/bpb_queue.sv
rtl/bpb_sqrt.sv
rtl/bpb_back.sv
rtl/blinn_phong_brdf_and_pdf_eval.sv
tb/bpb_checker.sv
tb/testbench.sv
